// ===== hdl/ttg_pkg.sv =====
package ttg_pkg;

    // Field and datapath widths
    localparam int POS_W  = 32;
    localparam int TEX_W  = 24;
    localparam int OUT_W  = 16;
    localparam int EDGE_W = POS_W + 1;
    localparam int DUV_W  = TEX_W + 1;
    localparam int PROD_W = EDGE_W + DUV_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int NORM_W = 30;
    localparam int SQ_W   = 2 * NORM_W;
    localparam int ROOT_W = 64;
    localparam int LEN_W  = 32;
    localparam int OUT_SH = 14;
    localparam int NUM_W  = NORM_W + OUT_SH + 1;
    localparam int QUO_W  = 16;
    localparam int CNT_W  = 6;

    localparam int QUEUE_DEPTH = 2;

    // Unit length in Q1.14
    localparam logic [QUO_W-1:0] OUT_ONE = 16'd16384;

    // Normalization window for the largest magnitude
    localparam logic [ACC_W-1:0] NORM_HIGH = ACC_W'(64'd1 << 30);
    localparam logic [ACC_W-1:0] NORM_LOW  = ACC_W'(64'd1 << 29);

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [TEX_W-1:0] tex_u;
        logic signed [TEX_W-1:0] tex_v;
    } vtx_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic                    degenerate;
    } tan_t;

    typedef struct packed {
        logic signed [EDGE_W-1:0] e1x;
        logic signed [EDGE_W-1:0] e1y;
        logic signed [EDGE_W-1:0] e1z;
        logic signed [EDGE_W-1:0] e2x;
        logic signed [EDGE_W-1:0] e2y;
        logic signed [EDGE_W-1:0] e2z;
        logic signed [DUV_W-1:0]  du1;
        logic signed [DUV_W-1:0]  dv1;
        logic signed [DUV_W-1:0]  du2;
        logic signed [DUV_W-1:0]  dv2;
    } job_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_MAG  = 8'b0000_0100,
        ST_NORM = 8'b0000_1000,
        ST_SQ   = 8'b0001_0000,
        ST_SQRT = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } back_state_t;

endpackage

// ===== hdl/ttg_front.sv =====
module ttg_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ttg_pkg::vtx_t s_data,
    output logic          job_valid,
    input  logic          job_ready,
    output ttg_pkg::job_t job_data
);

    logic [1:0]    corner_count_reg;
    logic [1:0]    corner_count_next;
    ttg_pkg::vtx_t c0_reg;
    ttg_pkg::vtx_t c1_reg;
    logic          third;
    logic          xfer;

    // Third corner closes a triangle and needs room in the queue
    assign third     = corner_count_reg[1];
    assign s_ready   = !third || job_ready;
    assign job_valid = s_valid && third;
    assign xfer      = s_valid && s_ready;

    // Form edges and texcoord deltas
    always_comb begin
        job_data.e1x = ttg_pkg::EDGE_W'(c1_reg.pos_x) - ttg_pkg::EDGE_W'(c0_reg.pos_x);
        job_data.e1y = ttg_pkg::EDGE_W'(c1_reg.pos_y) - ttg_pkg::EDGE_W'(c0_reg.pos_y);
        job_data.e1z = ttg_pkg::EDGE_W'(c1_reg.pos_z) - ttg_pkg::EDGE_W'(c0_reg.pos_z);
        job_data.e2x = ttg_pkg::EDGE_W'(s_data.pos_x) - ttg_pkg::EDGE_W'(c0_reg.pos_x);
        job_data.e2y = ttg_pkg::EDGE_W'(s_data.pos_y) - ttg_pkg::EDGE_W'(c0_reg.pos_y);
        job_data.e2z = ttg_pkg::EDGE_W'(s_data.pos_z) - ttg_pkg::EDGE_W'(c0_reg.pos_z);
        job_data.du1 = ttg_pkg::DUV_W'(c1_reg.tex_u) - ttg_pkg::DUV_W'(c0_reg.tex_u);
        job_data.dv1 = ttg_pkg::DUV_W'(c1_reg.tex_v) - ttg_pkg::DUV_W'(c0_reg.tex_v);
        job_data.du2 = ttg_pkg::DUV_W'(s_data.tex_u) - ttg_pkg::DUV_W'(c0_reg.tex_u);
        job_data.dv2 = ttg_pkg::DUV_W'(s_data.tex_v) - ttg_pkg::DUV_W'(c0_reg.tex_v);
    end

    // Advance the corner count
    always_comb begin
        corner_count_next = corner_count_reg;
        if (xfer) begin
            corner_count_next = third ? 2'd0 : corner_count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_count_reg <= 2'd0;
        end else begin
            corner_count_reg <= corner_count_next;
        end
    end

    // Hold the first two corners
    always_ff @(posedge aclk) begin
        if (xfer && !third) begin
            if (corner_count_reg[0]) begin
                c1_reg <= s_data;
            end else begin
                c0_reg <= s_data;
            end
        end
    end

endmodule

// ===== hdl/ttg_queue.sv =====
module ttg_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  ttg_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ttg_pkg::job_t pop_data
);

    localparam int PTR_W = $clog2(ttg_pkg::QUEUE_DEPTH);

    ttg_pkg::job_t          mem_reg [ttg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W:0]         count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = count_reg != (PTR_W+1)'(ttg_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/ttg_back.sv =====
module ttg_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  ttg_pkg::job_t job_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ttg_pkg::tan_t m_data
);

    localparam int ACC_W  = ttg_pkg::ACC_W;
    localparam int PROD_W = ttg_pkg::PROD_W;
    localparam int EDGE_W = ttg_pkg::EDGE_W;
    localparam int DUV_W  = ttg_pkg::DUV_W;
    localparam int NORM_W = ttg_pkg::NORM_W;
    localparam int SQ_W   = ttg_pkg::SQ_W;
    localparam int ROOT_W = ttg_pkg::ROOT_W;
    localparam int LEN_W  = ttg_pkg::LEN_W;
    localparam int NUM_W  = ttg_pkg::NUM_W;
    localparam int QUO_W  = ttg_pkg::QUO_W;
    localparam int OUT_W  = ttg_pkg::OUT_W;
    localparam int CNT_W  = ttg_pkg::CNT_W;
    localparam int LOW_W  = 16;

    ttg_pkg::back_state_t     state_reg;
    ttg_pkg::job_t            job_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               comp_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg [4];
    logic [ACC_W-1:0]         a_reg [3];
    logic [ACC_W-1:0]         m_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [ROOT_W-1:0]        sum_reg;
    logic [ROOT_W-1:0]        x_reg;
    logic [ROOT_W-1:0]        res_reg;
    logic [ROOT_W-1:0]        bit_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W:0]           rem_reg;
    logic [LOW_W-1:0]         low_reg;
    logic [QUO_W-1:0]         q_reg;
    logic signed [OUT_W-1:0]  tan_reg [3];
    logic                     degen_reg;
    logic                     m_valid_reg;
    ttg_pkg::tan_t            m_data_reg;

    logic signed [DUV_W-1:0]  op_a;
    logic signed [EDGE_W-1:0] op_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [2:0]               acc_idx;
    logic [ACC_W-1:0]         mag [3];
    logic [ACC_W-1:0]         max01;
    logic [ACC_W-1:0]         sel_a;
    logic [1:0]               sel_idx;
    logic [SQ_W-1:0]          sq_p;
    logic [ROOT_W-1:0]        root_t;
    logic                     root_ge;
    logic [ROOT_W-1:0]        res_step;
    logic [NUM_W-1:0]         div_num;
    logic [LEN_W:0]           trial;
    logic                     q_bit;
    logic [QUO_W-1:0]         q_fin;
    logic [QUO_W-1:0]         q_clamp;
    logic                     neg;
    logic                     out_load;

    assign job_ready = state_reg == ttg_pkg::ST_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_load  = (state_reg == ttg_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    // Shared multiplier operands: even steps dv2, odd steps dv1
    always_comb begin
        op_a = cnt_reg[0] ? job_reg.dv1 : job_reg.dv2;
        case (cnt_reg[2:0])
            3'd0:    op_b = job_reg.e1x;
            3'd1:    op_b = job_reg.e2x;
            3'd2:    op_b = job_reg.e1y;
            3'd3:    op_b = job_reg.e2y;
            3'd4:    op_b = job_reg.e1z;
            3'd5:    op_b = job_reg.e2z;
            3'd6:    op_b = EDGE_W'(job_reg.du1);
            default: op_b = EDGE_W'(job_reg.du2);
        endcase
        mul_p   = op_a * op_b;
        acc_idx = 3'(cnt_reg - 1'b1);
    end

    // Magnitudes and their maximum
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = acc_reg[i][ACC_W-1] ? ACC_W'(-acc_reg[i]) : ACC_W'(acc_reg[i]);
        end
        max01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    end

    // Component select for squaring and division
    always_comb begin
        sel_idx = (state_reg == ttg_pkg::ST_DIV) ? comp_reg : cnt_reg[1:0];
        case (sel_idx)
            2'd0:    sel_a = a_reg[0];
            2'd1:    sel_a = a_reg[1];
            default: sel_a = a_reg[2];
        endcase
        sq_p = SQ_W'(sel_a[NORM_W-1:0]) * SQ_W'(sel_a[NORM_W-1:0]);
    end

    // One step of the integer square root
    always_comb begin
        root_t   = res_reg + bit_reg;
        root_ge  = x_reg >= root_t;
        res_step = root_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
    end

    // One step of the restoring division
    always_comb begin
        div_num = {1'b0, sel_a[NORM_W-1:0], ttg_pkg::OUT_SH'(0)}
                  + NUM_W'(len_reg >> 1);
        trial   = {rem_reg[LEN_W-1:0], low_reg[LOW_W-1]};
        q_bit   = trial >= (LEN_W+1)'(len_reg);
        q_fin   = {q_reg[QUO_W-2:0], q_bit};
        q_clamp = (q_fin > ttg_pkg::OUT_ONE) ? ttg_pkg::OUT_ONE : q_fin;
        case (comp_reg)
            2'd0:    neg = acc_reg[0][ACC_W-1] ^ acc_reg[3][ACC_W-1];
            2'd1:    neg = acc_reg[1][ACC_W-1] ^ acc_reg[3][ACC_W-1];
            default: neg = acc_reg[2][ACC_W-1] ^ acc_reg[3][ACC_W-1];
        endcase
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ttg_pkg::ST_IDLE;
        end else begin
            case (state_reg)
                ttg_pkg::ST_IDLE: begin
                    if (job_valid) begin
                        state_reg <= ttg_pkg::ST_MUL;
                    end
                end
                ttg_pkg::ST_MUL: begin
                    if (cnt_reg == CNT_W'(8)) begin
                        state_reg <= ttg_pkg::ST_MAG;
                    end
                end
                ttg_pkg::ST_MAG: begin
                    state_reg <= ttg_pkg::ST_NORM;
                end
                ttg_pkg::ST_NORM: begin
                    if (acc_reg[3] == '0 || m_reg == '0) begin
                        state_reg <= ttg_pkg::ST_OUT;
                    end else if (m_reg < ttg_pkg::NORM_HIGH && m_reg >= ttg_pkg::NORM_LOW) begin
                        state_reg <= ttg_pkg::ST_SQ;
                    end
                end
                ttg_pkg::ST_SQ: begin
                    if (cnt_reg == CNT_W'(3)) begin
                        state_reg <= ttg_pkg::ST_SQRT;
                    end
                end
                ttg_pkg::ST_SQRT: begin
                    if (cnt_reg == CNT_W'(ROOT_W/2 - 1)) begin
                        state_reg <= ttg_pkg::ST_DIV;
                    end
                end
                ttg_pkg::ST_DIV: begin
                    if (cnt_reg == CNT_W'(QUO_W) && comp_reg == 2'd2) begin
                        state_reg <= ttg_pkg::ST_OUT;
                    end
                end
                ttg_pkg::ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ttg_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= ttg_pkg::ST_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ttg_pkg::ST_IDLE: begin
                job_reg <= job_data;
                cnt_reg <= '0;
            end
            ttg_pkg::ST_MUL: begin
                prod_reg <= mul_p;
                if (cnt_reg != '0) begin
                    if (acc_idx[0]) begin
                        acc_reg[acc_idx[2:1]] <= acc_reg[acc_idx[2:1]] - ACC_W'(prod_reg);
                    end else begin
                        acc_reg[acc_idx[2:1]] <= ACC_W'(prod_reg);
                    end
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            ttg_pkg::ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    a_reg[i] <= mag[i];
                end
                m_reg     <= (max01 > mag[2]) ? max01 : mag[2];
                degen_reg <= 1'b0;
            end
            ttg_pkg::ST_NORM: begin
                cnt_reg <= '0;
                if (acc_reg[3] == '0 || m_reg == '0) begin
                    degen_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        tan_reg[i] <= '0;
                    end
                end else if (m_reg >= ttg_pkg::NORM_HIGH) begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++) begin
                        a_reg[i] <= a_reg[i] >> 1;
                    end
                end else if (m_reg < ttg_pkg::NORM_LOW) begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++) begin
                        a_reg[i] <= a_reg[i] << 1;
                    end
                end
            end
            ttg_pkg::ST_SQ: begin
                sq_reg <= sq_p;
                if (cnt_reg == '0) begin
                    sum_reg <= '0;
                end else begin
                    sum_reg <= sum_reg + ROOT_W'(sq_reg);
                end
                if (cnt_reg == CNT_W'(3)) begin
                    x_reg   <= sum_reg + ROOT_W'(sq_reg);
                    res_reg <= '0;
                    bit_reg <= ROOT_W'(1) << (ROOT_W - 2);
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ttg_pkg::ST_SQRT: begin
                if (root_ge) begin
                    x_reg <= x_reg - root_t;
                end
                res_reg <= res_step;
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == CNT_W'(ROOT_W/2 - 1)) begin
                    len_reg  <= res_step[LEN_W-1:0];
                    cnt_reg  <= '0;
                    comp_reg <= 2'd0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ttg_pkg::ST_DIV: begin
                if (cnt_reg == '0) begin
                    rem_reg <= (LEN_W+1)'(div_num >> LOW_W);
                    low_reg <= div_num[LOW_W-1:0];
                    q_reg   <= '0;
                    cnt_reg <= cnt_reg + 1'b1;
                end else begin
                    rem_reg <= q_bit ? (trial - (LEN_W+1)'(len_reg)) : trial;
                    low_reg <= low_reg << 1;
                    q_reg   <= q_fin;
                    if (cnt_reg == CNT_W'(QUO_W)) begin
                        tan_reg[comp_reg] <= neg ? OUT_W'(-q_clamp) : OUT_W'(q_clamp);
                        comp_reg          <= comp_reg + 2'd1;
                        cnt_reg           <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.tangent_x  <= tan_reg[0];
            m_data_reg.tangent_y  <= tan_reg[1];
            m_data_reg.tangent_z  <= tan_reg[2];
            m_data_reg.degenerate <= degen_reg;
        end
    end

endmodule

// ===== hdl/triangle_tangent_generator.sv =====
// Channel   Ports                       Carries
// input     s_valid s_ready s_data      one vertex: position xyz, texcoord uv
// result    m_valid m_ready m_data      one tangent xyz (Q1.14) and degenerate flag
//
// A vertex is taken whenever s_ready is high; every third vertex queues one triangle job.
// The back end runs one job at a time (shared multiplier, one-step shifter,
// bit-per-cycle square root and divider); its time per triangle is set mostly
// by the root, the division and the shift count, and is shorter when degenerate.
// Reset (aresetn, synchronous) clears the corner count, queue and sequencer.
// A full two-entry queue stalls the third vertex; m_ready low stalls the back end.
module triangle_tangent_generator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ttg_pkg::vtx_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ttg_pkg::tan_t m_data
);

    logic          push_valid;
    logic          push_ready;
    ttg_pkg::job_t push_data;
    logic          pop_valid;
    logic          pop_ready;
    ttg_pkg::job_t pop_data;

    ttg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job_data  (push_data)
    );

    ttg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ttg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
